/* design/plht_pkg.sv */
package plht_pkg;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ENTRY_W    = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PIN_W      = 16;
  localparam int unsigned MAX_OPEN_W = 9;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned TOTAL_W    = 9;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [MAX_OPEN_W-1:0] MAX_OPEN_RESET = 9'd256;
  localparam logic [PIN_W-1:0]      PIN_TOP        = 16'hFFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD     = 2'd0,
    KIND_ALLOC   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_REMOVE  = 2'd3
  } plht_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_VICTIM = 2'd1,
    STAT_OPEN_FAIL = 2'd2,
    STAT_UNDERFLOW = 2'd3
  } plht_status_e;

  // One table entry as it sits in the memory.
  typedef struct packed {
    logic              known;
    logic              is_open;
    logic [PIN_W-1:0]  pins;
    logic [TIME_W-1:0] last_use;
  } plht_word_t;

  // Outcome of a victim scan. Only entries that an item can address are ever
  // known, so the victim index fits the entry field.
  typedef struct packed {
    logic               done;
    logic               found;
    logic [ENTRY_W-1:0] idx;
    logic [TIME_W-1:0]  last_use;
  } plht_scan_t;

endpackage

/* design/pinned_lru_handle_table.sv */
// Channel   | Direction | Signals                       | Contents
// ----------+-----------+-------------------------------+------------------------------------
// s_axis    | in        | tvalid, tready, tdata, tuser  | one operation on a handle entry
// m_axis    | out       | tvalid, tready, tdata         | one result for each operation
// cfg       | in        | cfg_valid_i, cfg_ready_o, data| open-entry limit (max_open)
//
// Add, release, remove and an allocate that needs no eviction go through S_READ, which reads
// the entry, and S_EXEC, which modifies it, writes it back and registers the result.
// The next item is taken once the block is back in S_IDLE.
// An allocate of a closed entry that hits the open limit scans the whole table through the
// single memory read port, one entry per cycle.
// After reset the table memory is cleared one entry per cycle in a pass
// during which no item is accepted; configuration writes are taken at any time.
// A finished result waits in the output register while the next item is taken;
// the block stalls before writing back only if that register is still full.
module pinned_lru_handle_table #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] entry, [8] open_fails, [40:9] now, [47:41] zero
  input  logic [plht_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [plht_pkg::KIND_W-1:0]    s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [2] closed_valid, [10:3] closed_index, [11] entry_open,
  // [27:12] pin_count, [36:28] open_total, [39:37] zero
  output logic [plht_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [plht_pkg::MAX_OPEN_W-1:0] cfg_data_i
);

  localparam int unsigned AW  = $clog2(ENTRIES);
  localparam int unsigned CW  = $clog2(ENTRIES + 1);
  localparam int unsigned MOW = plht_pkg::MAX_OPEN_W;
  localparam int unsigned MW  = (CW > MOW) ? CW : MOW;
  localparam int unsigned EW  = plht_pkg::ENTRY_W;
  localparam int unsigned TW  = plht_pkg::TIME_W;
  localparam int unsigned PW  = plht_pkg::PIN_W;
  localparam int unsigned OTW = plht_pkg::TOTAL_W;
  localparam int unsigned ODW = plht_pkg::OUT_DATA_W;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SCAN,
    S_EVICT
  } state_e;

  state_e                      state_q;
  logic [AW-1:0]               clr_q;
  plht_pkg::plht_kind_e        kind_q;
  logic [EW-1:0]               entry_q;
  logic                        fails_q;
  logic [TW-1:0]               now_q;
  plht_pkg::plht_word_t        word_q;
  logic                        evicted_q;
  logic                        novictim_q;
  logic                        closed_q;
  logic [EW-1:0]               closed_idx_q;
  logic [CW-1:0]               open_cnt_q;
  logic [MOW-1:0]              max_open_q;
  logic                        m_valid_q;
  logic [ODW-1:0]              m_data_q;

  // Memory and scan wiring.
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  plht_pkg::plht_word_t        mem_wdata;
  logic [AW-1:0]               mem_raddr;
  plht_pkg::plht_word_t        mem_rdata;
  logic [AW-1:0]               scan_raddr;
  plht_pkg::plht_scan_t        scan_res;
  logic                        scan_start;

  // Read, modify, write of the target entry.
  logic                        in_range;
  logic                        limit_hit;
  logic                        go_scan;
  logic                        do_write;
  logic                        commit;
  plht_pkg::plht_word_t        w_new;
  logic [CW-1:0]               cnt_new;
  plht_pkg::plht_status_e      status;
  logic                        cv;
  logic [EW-1:0]               ci;
  logic                        eo;
  logic [PW-1:0]               pc;
  plht_pkg::plht_word_t        victim_word;

  plht_mem #(
    .ENTRIES(ENTRIES),
    .AW     (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  plht_scan #(
    .ENTRIES(ENTRIES),
    .AW     (AW)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(scan_start),
    .raddr_o(scan_raddr),
    .rdata_i(mem_rdata),
    .res_o  (scan_res)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Entries beyond the table leave everything as it is.
  assign in_range  = (32'(entry_q) < ENTRIES);
  assign limit_hit = (MW'(open_cnt_q) >= MW'(max_open_q));

  always_comb begin
    w_new    = word_q;
    cnt_new  = open_cnt_q;
    status   = plht_pkg::STAT_OK;
    cv       = closed_q;
    ci       = closed_idx_q;
    do_write = 1'b0;
    go_scan  = 1'b0;
    if (in_range) begin
      unique case (kind_q)
        plht_pkg::KIND_ADD: begin
          // A newly known entry starts clean but keeps its open mark.
          if (!word_q.known) begin
            w_new.known    = 1'b1;
            w_new.pins     = '0;
            w_new.last_use = '0;
            do_write       = 1'b1;
          end
        end
        plht_pkg::KIND_ALLOC: begin
          if (!word_q.is_open && !evicted_q && !novictim_q && limit_hit) begin
            go_scan = 1'b1;
          end else if (!word_q.is_open && novictim_q) begin
            status = plht_pkg::STAT_NO_VICTIM;
          end else if (!word_q.is_open && fails_q) begin
            status = plht_pkg::STAT_OPEN_FAIL;
          end else begin
            w_new.last_use = now_q;
            if (word_q.pins != plht_pkg::PIN_TOP) begin
              w_new.pins = word_q.pins + PW'(1);
            end
            if (!word_q.is_open) begin
              w_new.is_open = 1'b1;
              if (open_cnt_q < CW'(ENTRIES)) begin
                cnt_new = open_cnt_q + CW'(1);
              end
            end
            do_write = 1'b1;
          end
        end
        plht_pkg::KIND_RELEASE: begin
          if (word_q.pins == '0) begin
            status = plht_pkg::STAT_UNDERFLOW;
          end else begin
            w_new.pins = word_q.pins - PW'(1);
            do_write   = 1'b1;
          end
        end
        plht_pkg::KIND_REMOVE: begin
          if (word_q.is_open) begin
            w_new.is_open = 1'b0;
            if (open_cnt_q != '0) begin
              cnt_new = open_cnt_q - CW'(1);
            end
            cv = 1'b1;
            ci = entry_q;
          end
          w_new.known = 1'b0;
          do_write    = 1'b1;
        end
        default: begin
        end
      endcase
    end
    eo = in_range ? w_new.is_open : 1'b0;
    pc = in_range ? w_new.pins : '0;
  end

  assign commit     = (state_q == S_EXEC) && !go_scan && (!m_valid_q || m_axis_tready);
  assign scan_start = (state_q == S_EXEC) && go_scan;

  // The victim stays known and unpinned; only its open mark drops.
  always_comb begin
    victim_word          = '0;
    victim_word.known    = 1'b1;
    victim_word.is_open  = 1'b0;
    victim_word.last_use = scan_res.last_use;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(entry_q);
    mem_wdata = w_new;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      S_EVICT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(scan_res.idx);
        mem_wdata = victim_word;
      end
      S_EXEC: begin
        mem_we = commit && do_write;
      end
      default: begin
      end
    endcase
  end

  assign mem_raddr = (state_q == S_SCAN) ? scan_raddr : AW'(s_axis_tdata[7:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      kind_q       <= plht_pkg::KIND_ADD;
      entry_q      <= '0;
      fails_q      <= 1'b0;
      now_q        <= '0;
      word_q       <= '0;
      evicted_q    <= 1'b0;
      novictim_q   <= 1'b0;
      closed_q     <= 1'b0;
      closed_idx_q <= '0;
      open_cnt_q   <= '0;
      max_open_q   <= plht_pkg::MAX_OPEN_RESET;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        max_open_q <= cfg_data_i;
      end

      if (commit) begin
        m_valid_q <= 1'b1;
        m_data_q  <= {3'b000, OTW'(cnt_new), pc, eo, ci, cv, status};
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            kind_q       <= plht_pkg::plht_kind_e'(s_axis_tuser);
            entry_q      <= s_axis_tdata[7:0];
            fails_q      <= s_axis_tdata[8];
            now_q        <= s_axis_tdata[40:9];
            evicted_q    <= 1'b0;
            novictim_q   <= 1'b0;
            closed_q     <= 1'b0;
            closed_idx_q <= '0;
            state_q      <= S_READ;
          end
        end
        S_READ: begin
          word_q  <= mem_rdata;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (go_scan) begin
            state_q <= S_SCAN;
          end else if (commit) begin
            open_cnt_q <= cnt_new;
            state_q    <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_res.done) begin
            if (scan_res.found) begin
              state_q <= S_EVICT;
            end else begin
              novictim_q <= 1'b1;
              state_q    <= S_EXEC;
            end
          end
        end
        S_EVICT: begin
          if (open_cnt_q != '0) begin
            open_cnt_q <= open_cnt_q - CW'(1);
          end
          evicted_q    <= 1'b1;
          closed_q     <= 1'b1;
          closed_idx_q <= scan_res.idx;
          state_q      <= S_EXEC;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/plht_mem.sv */
module plht_mem #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned AW      = 8
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  plht_pkg::plht_word_t wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output plht_pkg::plht_word_t rdata_o
);

  plht_pkg::plht_word_t mem [ENTRIES];
  plht_pkg::plht_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/plht_scan.sv */
module plht_scan #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned AW      = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic [AW-1:0]        raddr_o,
  input  plht_pkg::plht_word_t rdata_i,
  output plht_pkg::plht_scan_t res_o
);

  localparam int unsigned EW = plht_pkg::ENTRY_W;
  localparam int unsigned TW = plht_pkg::TIME_W;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  logic          busy_q;
  logic [AW-1:0] cnt_q;
  logic          dv_q;
  logic [AW-1:0] didx_q;
  logic          found_q;
  logic [EW-1:0] best_idx_q;
  logic [TW-1:0] best_t_q;
  logic          done_q;
  logic          cand;
  logic          take;

  // An entry may be evicted when it is known, open and unpinned. A strict
  // compare keeps the lowest index among equal times.
  always_comb begin
    cand = dv_q && rdata_i.known && rdata_i.is_open && (rdata_i.pins == '0);
    take = cand && (!found_q || (rdata_i.last_use < best_t_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      cnt_q      <= '0;
      dv_q       <= 1'b0;
      didx_q     <= '0;
      found_q    <= 1'b0;
      best_idx_q <= '0;
      best_t_q   <= '0;
      done_q     <= 1'b0;
    end else begin
      dv_q   <= busy_q;
      didx_q <= cnt_q;
      done_q <= dv_q && (didx_q == LAST);
      if (start_i) begin
        busy_q  <= 1'b1;
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (busy_q) begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == LAST) begin
            busy_q <= 1'b0;
          end
        end
        if (take) begin
          found_q    <= 1'b1;
          best_idx_q <= EW'(didx_q);
          best_t_q   <= rdata_i.last_use;
        end
      end
    end
  end

  assign raddr_o        = cnt_q;
  assign res_o.done     = done_q;
  assign res_o.found    = found_q;
  assign res_o.idx      = best_idx_q;
  assign res_o.last_use = best_t_q;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

// Testbench for the pinned LRU handle table.
//
// The table is driven through its operation stream. An independent
// predictor follows every accepted operation and queues the result that the
// table must produce. A checker compares each result the table sends with
// the oldest queued prediction, field by field.
//
// Stimulus runs in several steps:
//  - Short directed sequences cover adds, allocates, releases and removes.
//    They also cover unknown entries, open failures, victim ties, a victim
//    stamped with the largest time, the no-victim case, and limits of zero
//    and above the table size.
//  - One entry is pinned several times and then released past zero.
//  - The result side holds off for a long stretch so that the table fills
//    up and stalls its input.
//  - Random traffic runs in phases, each with its own open-entry limit and
//    its own small pool of entries, so that evictions happen often.
module testbench;

  localparam int unsigned TABLE_SIZE   = 256;
  // Cycles without a handshake on any channel before the run is declared hung. This
  // covers the clearing pass after reset, a full eviction scan, the long
  // result-side hold-off and the longest sender gap, with room to spare.
  localparam int unsigned HANG_LIMIT   = 4000;
  // Long enough for a full eviction scan of the table, so a stray late
  // result would show up within this many cycles.
  localparam int unsigned SETTLE_WAIT  = 300;
  localparam int unsigned PHASE_ITEMS  = 120;
  localparam int unsigned LONG_HOLD    = 300;

  // One result of the table, unpacked into its fields.
  typedef struct {
    plht_pkg::plht_status_e           status;
    logic                             closed_valid;
    logic [plht_pkg::ENTRY_W-1:0]     closed_index;
    logic                             entry_open;
    logic [plht_pkg::PIN_W-1:0]       pin_count;
    logic [plht_pkg::TOTAL_W-1:0]     open_total;
  } handle_result_t;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  // [7:0] entry, [8] open_fails, [40:9] now, [47:41] zero
  logic [plht_pkg::IN_DATA_W-1:0]    s_axis_tdata  = '0;
  // [1:0] kind
  logic [plht_pkg::KIND_W-1:0]       s_axis_tuser  = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  // [1:0] status, [2] closed_valid, [10:3] closed_index, [11] entry_open,
  // [27:12] pin_count, [36:28] open_total, [39:37] zero
  logic [plht_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
  logic                              cfg_valid_i   = 1'b0;
  logic                              cfg_ready_o;
  logic [plht_pkg::MAX_OPEN_W-1:0]   cfg_data_i    = '0;

  pinned_lru_handle_table #(
    .ENTRIES(TABLE_SIZE)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Predicted table contents. They start cleared, as the table does after
  // its clearing pass.
  bit                           is_known [TABLE_SIZE];
  bit                           is_open  [TABLE_SIZE];
  bit [plht_pkg::PIN_W-1:0]     pin_of   [TABLE_SIZE];
  bit [plht_pkg::TIME_W-1:0]    stamp_of [TABLE_SIZE];
  int unsigned                  open_tally = 0;
  int unsigned                  open_limit = plht_pkg::MAX_OPEN_RESET;

  handle_result_t               awaited_results [$];
  int unsigned                  mismatches     = 0;
  int unsigned                  idle_cycles    = 0;
  int unsigned                  hold_off_left  = 0;
  bit                           steady_flow    = 1'b0;
  bit                           offering       = 1'b0;
  logic [plht_pkg::TIME_W-1:0]  time_base      = '0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Closes one predicted entry. The open count never drops below zero.
  function automatic void close_handle(int unsigned idx);
    is_open[idx] = 1'b0;
    if (open_tally > 0) open_tally--;
  endfunction

  // Applies one operation to the predicted table and returns the result
  // that the table must report for it.
  function automatic handle_result_t apply_handle_op(
      plht_pkg::plht_kind_e kind,
      logic [plht_pkg::ENTRY_W-1:0] idx,
      logic fails,
      logic [plht_pkg::TIME_W-1:0] stamp);
    handle_result_t               r;
    bit                           proceed;
    bit                           found;
    int unsigned                  victim;
    logic [plht_pkg::TIME_W-1:0]  oldest;
    r.status       = plht_pkg::STAT_OK;
    r.closed_valid = 1'b0;
    r.closed_index = '0;
    proceed        = 1'b1;
    found          = 1'b0;
    victim         = 0;
    oldest         = '0;
    unique case (kind)
      plht_pkg::KIND_ADD: begin
        // Adding a known entry changes nothing. A new entry starts with no
        // pins and a zero stamp but keeps its open mark.
        if (!is_known[idx]) begin
          is_known[idx] = 1'b1;
          pin_of[idx]   = '0;
          stamp_of[idx] = '0;
        end
      end
      plht_pkg::KIND_ALLOC: begin
        // An entry that is already open skips the limit check.
        if (!is_open[idx]) begin
          if (open_tally >= open_limit) begin
            // Oldest known, open, unpinned entry; a tie keeps the lower index.
            for (int i = 0; i < TABLE_SIZE; i++) begin
              if (is_known[i] && is_open[i] && pin_of[i] == '0 &&
                  (!found || stamp_of[i] < oldest)) begin
                found  = 1'b1;
                victim = i;
                oldest = stamp_of[i];
              end
            end
            if (found) begin
              close_handle(victim);
              r.closed_valid = 1'b1;
              r.closed_index = plht_pkg::ENTRY_W'(victim);
            end else begin
              r.status = plht_pkg::STAT_NO_VICTIM;
              proceed  = 1'b0;
            end
          end
          // A failed open leaves any eviction in place.
          if (proceed) begin
            if (fails) begin
              r.status = plht_pkg::STAT_OPEN_FAIL;
              proceed  = 1'b0;
            end else begin
              is_open[idx] = 1'b1;
              if (open_tally < TABLE_SIZE) open_tally++;
            end
          end
        end
        if (proceed) begin
          stamp_of[idx] = stamp;
          if (pin_of[idx] != plht_pkg::PIN_TOP) pin_of[idx]++;
        end
      end
      plht_pkg::KIND_RELEASE: begin
        if (pin_of[idx] == '0) begin
          r.status = plht_pkg::STAT_UNDERFLOW;
        end else begin
          pin_of[idx]--;
        end
      end
      plht_pkg::KIND_REMOVE: begin
        // A remove keeps the pin count and the stamp.
        if (is_open[idx]) begin
          close_handle(idx);
          r.closed_valid = 1'b1;
          r.closed_index = idx;
        end
        is_known[idx] = 1'b0;
      end
    endcase
    r.entry_open = is_open[idx];
    r.pin_count  = pin_of[idx];
    r.open_total = plht_pkg::TOTAL_W'(open_tally);
    return r;
  endfunction

  // Gap before an item or a ready pulse: mostly none or short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one operation and records its predicted result once accepted.
  // Valid stays high afterwards so that a following item with no gap goes
  // out back to back.
  task automatic send_op(plht_pkg::plht_kind_e kind, logic [plht_pkg::ENTRY_W-1:0] idx,
                         logic fails, logic [plht_pkg::TIME_W-1:0] stamp);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      if (offering) begin
        s_axis_tvalid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {7'd0, stamp, fails, idx};
    s_axis_tuser  <= kind;
    s_axis_tvalid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    awaited_results.insert(awaited_results.size(), apply_handle_op(kind, idx, fails, stamp));
  endtask

  // Stops offering items and waits until every predicted result has come.
  task automatic wait_for_results();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // Changes the open-entry limit. The table is idle by then.
  task automatic write_open_limit(int unsigned value);
    wait_for_results();
    cfg_data_i  <= plht_pkg::MAX_OPEN_W'(value);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    open_limit = value;
  endtask

  // One random operation. Most items target a small pool so that entries
  // are added, opened, released and evicted over and over; a few hit any
  // entry. Stamps mostly climb, sometimes repeat to force ties, and now and
  // then take extreme or fully random values.
  task automatic send_random_op(int unsigned pool_base, int unsigned pool_size);
    int unsigned                  r;
    plht_pkg::plht_kind_e         kind;
    logic [plht_pkg::ENTRY_W-1:0] idx;
    logic                         fails;
    logic [plht_pkg::TIME_W-1:0]  stamp;
    r = $urandom_range(0, 99);
    if (r < 25) kind = plht_pkg::KIND_ADD;
    else if (r < 65) kind = plht_pkg::KIND_ALLOC;
    else if (r < 88) kind = plht_pkg::KIND_RELEASE;
    else kind = plht_pkg::KIND_REMOVE;
    if ($urandom_range(0, 9) == 0) begin
      idx = plht_pkg::ENTRY_W'($urandom_range(0, TABLE_SIZE - 1));
    end else begin
      idx = plht_pkg::ENTRY_W'((pool_base + $urandom_range(0, pool_size - 1)) % TABLE_SIZE);
    end
    fails = ($urandom_range(0, 9) == 0);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      stamp = $urandom;
    end else if (r < 12) begin
      stamp = '1;
    end else if (r < 16) begin
      stamp = '0;
    end else if (r < 30) begin
      stamp = time_base;
    end else begin
      time_base = time_base + $urandom_range(1, 50);
      stamp = time_base;
    end
    send_op(kind, idx, fails, stamp);
  endtask

  // Basic operations under the limit left at its reset value.
  task automatic test_directed_ops();
    send_op(plht_pkg::KIND_ADD,     8'd5,   1'b0, 32'h0000_0000);
    // A second add of a known entry changes nothing.
    send_op(plht_pkg::KIND_ADD,     8'd5,   1'b0, 32'h0000_0000);
    send_op(plht_pkg::KIND_ALLOC,   8'd5,   1'b0, 32'hFFFF_FFFF);
    // Allocating an open entry ignores the open failure flag.
    send_op(plht_pkg::KIND_ALLOC,   8'd5,   1'b1, 32'h0000_1234);
    send_op(plht_pkg::KIND_RELEASE, 8'd5,   1'b0, 32'h0000_0000);
    send_op(plht_pkg::KIND_RELEASE, 8'd5,   1'b0, 32'h0000_0000);
    // The pin count is already zero here.
    send_op(plht_pkg::KIND_RELEASE, 8'd5,   1'b0, 32'h0000_0000);
    // Restore the stamp on entry 5 to the largest time value.
    send_op(plht_pkg::KIND_ALLOC,   8'd5,   1'b0, 32'hFFFF_FFFF);
    send_op(plht_pkg::KIND_RELEASE, 8'd5,   1'b0, 32'h0000_0000);
    send_op(plht_pkg::KIND_ALLOC,   8'd9,   1'b1, 32'h5555_5555);
    // An unknown entry can still be opened. A later add clears its pins but
    // leaves it open.
    send_op(plht_pkg::KIND_ALLOC,   8'd255, 1'b0, 32'h8000_0000);
    send_op(plht_pkg::KIND_ADD,     8'd255, 1'b0, 32'hAAAA_AAAA);
    send_op(plht_pkg::KIND_REMOVE,  8'd255, 1'b0, 32'h0000_0000);
    send_op(plht_pkg::KIND_REMOVE,  8'd255, 1'b0, 32'h0000_0000);
    send_op(plht_pkg::KIND_ALLOC,   8'd0,   1'b0, 32'h0000_0000);
    send_op(plht_pkg::KIND_RELEASE, 8'd0,   1'b0, 32'h0000_0000);
  endtask

  // Victim choice at small limits. Entries 5 (stamp all ones) and 0 (not
  // yet known) are open and unpinned from the directed test.
  task automatic test_victim_choice();
    write_open_limit(2);
    send_op(plht_pkg::KIND_ADD,     8'd0, 1'b0, 32'h0);
    send_op(plht_pkg::KIND_ADD,     8'd7, 1'b0, 32'h0);
    send_op(plht_pkg::KIND_ADD,     8'd8, 1'b0, 32'h0);
    // Entry 0 is older than entry 5 and goes first.
    send_op(plht_pkg::KIND_ALLOC,   8'd7, 1'b0, 32'd100);
    // Entry 5 is now the only candidate despite its maximal stamp.
    send_op(plht_pkg::KIND_ALLOC,   8'd8, 1'b0, 32'd100);
    // Both open entries are pinned, so nothing can be evicted.
    send_op(plht_pkg::KIND_ALLOC,   8'd9, 1'b0, 32'd5);
    send_op(plht_pkg::KIND_RELEASE, 8'd7, 1'b0, 32'h0);
    send_op(plht_pkg::KIND_RELEASE, 8'd8, 1'b0, 32'h0);
    // Entries 7 and 8 tie; entry 7 is evicted even though the open fails.
    send_op(plht_pkg::KIND_ALLOC,   8'd9, 1'b1, 32'd7);
    send_op(plht_pkg::KIND_ALLOC,   8'd9, 1'b0, 32'd7);
    // With a limit of zero every allocate of a closed entry must evict.
    write_open_limit(0);
    send_op(plht_pkg::KIND_ALLOC,   8'd3, 1'b0, 32'd200);
    send_op(plht_pkg::KIND_ALLOC,   8'd4, 1'b0, 32'd201);
    // A limit above the table size is never reached.
    write_open_limit(511);
    send_op(plht_pkg::KIND_ALLOC,   8'd6, 1'b0, 32'd300);
    send_op(plht_pkg::KIND_ALLOC,   8'd2, 1'b0, 32'd301);
    send_op(plht_pkg::KIND_REMOVE,  8'd3, 1'b0, 32'h0);
  endtask

  // Pins one entry a dozen times, takes every pin back and one more so
  // that the count would drop below zero, then retires the entry and adds
  // it again.
  task automatic test_pin_counting();
    write_open_limit(256);
    steady_flow = 1'b1;
    send_op(plht_pkg::KIND_ADD, 8'd40, 1'b0, 32'h0);
    repeat (12) send_op(plht_pkg::KIND_ALLOC, 8'd40, 1'b0, $urandom);
    repeat (13) send_op(plht_pkg::KIND_RELEASE, 8'd40, 1'b0, 32'h0);
    send_op(plht_pkg::KIND_REMOVE, 8'd40, 1'b0, 32'h0);
    send_op(plht_pkg::KIND_ADD,    8'd40, 1'b0, 32'h0);
    steady_flow = 1'b0;
  endtask

  // The result side holds off for a long stretch while items keep coming,
  // so the table fills up and stalls its input. The sender then pauses until
  // all results are back.
  task automatic test_output_backpressure();
    write_open_limit(4);
    hold_off_left = LONG_HOLD;
    repeat (40) send_random_op(48, 8);
    wait_for_results();
  endtask

  // Random traffic in phases with different limits and pools. Small pools
  // with small limits keep the eviction scan busy.
  task automatic test_random_traffic();
    int unsigned limits [8] = '{1, 0, 3, 256, 8, 511, 2, 255};
    int unsigned pools  [8] = '{6, 5, 10, 40, 16, 30, 4, 64};
    for (int p = 0; p < 8; p++) begin
      write_open_limit(limits[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 2) wait_for_results();
        send_random_op(p * 32, pools[p]);
      end
    end
  endtask

  // Result side: ready drops for random gaps, and for a long stretch when a
  // test asks for one.
  initial begin
    int unsigned pause_left;
    pause_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_left != 0) begin
        hold_off_left--;
        m_axis_tready <= 1'b0;
      end else if (pause_left != 0) begin
        pause_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady_flow && $urandom_range(0, 99) < 25) pause_left = pick_gap();
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compares every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    handle_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, expected nothing, actual %h",
                 $time, m_axis_tdata);
      end else begin
        want = awaited_results.pop_front();
        check_field("status",       want.status,       m_axis_tdata[1:0]);
        check_field("closed_valid", want.closed_valid, m_axis_tdata[2]);
        check_field("closed_index", want.closed_index, m_axis_tdata[10:3]);
        check_field("entry_open",   want.entry_open,   m_axis_tdata[11]);
        check_field("pin_count",    want.pin_count,    m_axis_tdata[27:12]);
        check_field("open_total",   want.open_total,   m_axis_tdata[36:28]);
      end
    end
  end

  // Ends the run if nothing moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_ops();
    test_victim_choice();
    test_pin_counting();
    test_output_backpressure();
    test_random_traffic();
    wait_for_results();
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
